[sv/smt_pkg.sv]
// Package for the syslog message tokenizer: payload structs, codes and constants.
// Used by all modules of the tokenizer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package smt_pkg;

    localparam int LENGTH_COUNTER_WIDTH = 16;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_LBR   = 8'h5B;
    localparam logic [7:0] CH_RBR   = 8'h5D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] PRI_LIMIT_RESET = 8'd191;
    localparam logic [3:0] VER_MAX_RESET   = 4'd2;

    // Configuration register indexes.
    localparam logic [0:0] CFG_PRI_LIMIT = 1'b0;
    localparam logic [0:0] CFG_VER_MAX   = 1'b1;

    // Header phases.
    localparam logic [3:0] PH_LT      = 4'd0;
    localparam logic [3:0] PH_PRI     = 4'd1;
    localparam logic [3:0] PH_VER     = 4'd2;
    localparam logic [3:0] PH_TS      = 4'd3;
    localparam logic [3:0] PH_HOST    = 4'd4;
    localparam logic [3:0] PH_APP     = 4'd5;
    localparam logic [3:0] PH_PROC    = 4'd6;
    localparam logic [3:0] PH_MSGID   = 4'd7;
    localparam logic [3:0] PH_SDSTART = 4'd8;
    localparam logic [3:0] PH_SDNIL   = 4'd9;
    localparam logic [3:0] PH_SDEL    = 4'd10;
    localparam logic [3:0] PH_SDAFTER = 4'd11;
    localparam logic [3:0] PH_BODY    = 4'd12;
    localparam logic [3:0] PH_HALT    = 4'd13;

    // Positions inside a structured-data element.
    localparam logic [2:0] SUB_ID    = 3'd0;
    localparam logic [2:0] SUB_NAME  = 3'd1;
    localparam logic [2:0] SUB_QUOTE = 3'd2;
    localparam logic [2:0] SUB_VALUE = 3'd3;
    localparam logic [2:0] SUB_AFTER = 3'd4;
    localparam logic [2:0] SUB_SKIP  = 3'd5;

    // Field tags.
    localparam logic [3:0] TAG_NONE  = 4'd0;
    localparam logic [3:0] TAG_PRI   = 4'd1;
    localparam logic [3:0] TAG_SDID  = 4'd8;
    localparam logic [3:0] TAG_PNAME = 4'd9;
    localparam logic [3:0] TAG_PVAL  = 4'd10;
    localparam logic [3:0] TAG_BODY  = 4'd11;

    // Status codes.
    localparam logic [2:0] ST_RUN   = 3'd0;
    localparam logic [2:0] ST_DONE  = 3'd1;
    localparam logic [2:0] ST_NOLT  = 3'd2;
    localparam logic [2:0] ST_BADPRI = 3'd3;
    localparam logic [2:0] ST_BADVER = 3'd4;
    localparam logic [2:0] ST_EMPTY = 3'd5;
    localparam logic [2:0] ST_TRUNC = 3'd6;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_message;
    } t_in_item;

    typedef struct packed {
        logic [3:0] field_tag;
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       field_end;
        logic       field_is_nil;
        logic       sd_element_end;
        logic       sd_invalid;
        logic [7:0] prio_val;
        logic [4:0] facility;
        logic [2:0] severity;
        logic [2:0] status;
        logic       last;
    } t_out_item;

    // One classified byte: up to two result items travel together.
    typedef struct packed {
        logic      two;
        t_out_item first;
        t_out_item second;
    } t_entry;

endpackage
`default_nettype wire

[sv/syslog_message_tokenizer_unit.sv]
// Syslog message tokenizer top level: RFC 5424 field tagging.
// A result is offered when its byte's registered queue entry is at the head.
// Throughput: one byte per cycle unless the queue is full; a kept escape yields
// two results that take the output in turn, absorbed by a four-entry queue.
// Reset (synchronous, active low) clears parse state and the queue and restores
// the register defaults; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module syslog_message_tokenizer_unit import smt_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_data,
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_data,
    input  wire logic       i_cfg_valid,
    output logic            o_cfg_ready,
    input  wire logic [0:0] i_cfg_index,
    input  wire logic [7:0] i_cfg_data
);

    logic [7:0] r_pri_limit;
    logic [3:0] r_ver_max;
    logic       step, full, empty, pop;
    t_entry     front_entry, queue_entry;

    // Configuration registers.
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pri_limit <= PRI_LIMIT_RESET;
            r_ver_max   <= VER_MAX_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_PRI_LIMIT: r_pri_limit <= i_cfg_data;
                CFG_VER_MAX:   r_ver_max   <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    assign o_in_ready = !full;
    assign step = i_in_valid && o_in_ready;

    smt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_step(step), .i_item(i_in_data),
        .i_pri_limit(r_pri_limit), .i_ver_max(r_ver_max), .o_entry(front_entry)
    );

    smt_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(step), .i_entry(front_entry),
        .i_pop(pop), .o_full(full), .o_empty(empty), .o_entry(queue_entry)
    );

    smt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_empty(empty), .i_entry(queue_entry),
        .o_pop(pop), .o_valid(o_out_valid), .i_ready(i_out_ready), .o_item(o_out_data)
    );

`ifndef ASSERT_OFF
    // A result shown but not taken stays the same.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output changed while stalled");
    // No byte is taken while the queue is full.
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |-> !o_in_ready)
        else $error("input accepted into a full queue");
    // A result that is not the last of its byte is followed by its partner.
    a_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out_data.last |=> o_out_valid)
        else $error("second result of a pair missing");
`endif

endmodule
`default_nettype wire

[sv/smt_front.sv]
// Front part of the tokenizer: parse state machine that classifies each byte.
// Depends on smt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smt_front import smt_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_step,
    input  wire t_in_item   i_item,
    input  wire logic [7:0] i_pri_limit,
    input  wire logic [3:0] i_ver_max,
    output t_entry          o_entry
);

    localparam logic [LENGTH_COUNTER_WIDTH-1:0] LEN_MAX = '1;

    logic [3:0] r_phase, n_phase;
    logic [2:0] r_sub, n_sub;
    logic       r_esc, n_esc;
    logic [LENGTH_COUNTER_WIDTH-1:0] r_len, n_len;
    logic [7:0] r_first, n_first;
    logic [7:0] r_acc, n_acc;
    logic [2:0] r_err, n_err;

    // Registered state update; end of message restores reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_LT;
            r_sub   <= SUB_ID;
            r_esc   <= 1'b0;
            r_len   <= '0;
            r_first <= '0;
            r_acc   <= '0;
            r_err   <= ST_RUN;
        end else if (i_step) begin
            if (i_item.end_of_message) begin
                r_phase <= PH_LT;
                r_sub   <= SUB_ID;
                r_esc   <= 1'b0;
                r_len   <= '0;
                r_first <= '0;
                r_acc   <= '0;
                r_err   <= ST_RUN;
            end else begin
                r_phase <= n_phase;
                r_sub   <= n_sub;
                r_esc   <= n_esc;
                r_len   <= n_len;
                r_first <= n_first;
                r_acc   <= n_acc;
                r_err   <= n_err;
            end
        end
    end

    // Classification of one byte.
    always_comb begin
        logic [7:0] b;
        logic       eom;
        logic [11:0] prod;
        logic [2:0] status;
        logic       bump, bump_bsl, clr, nil;
        logic [3:0] tag0, tag1;
        logic [7:0] byte0;
        logic       v0, v1, fend, sdend, sdinv, two, err_now;
        logic [2:0] err_code;
        logic [LENGTH_COUNTER_WIDTH-1:0] len_a;
        logic [7:0] first_a;

        b = i_item.data_byte;
        eom = i_item.end_of_message;
        n_phase = r_phase; n_sub = r_sub; n_esc = r_esc;
        n_acc = r_acc; n_err = r_err;
        bump = 1'b0; bump_bsl = 1'b0; clr = 1'b0;
        tag0 = TAG_NONE; tag1 = TAG_NONE; byte0 = b;
        v0 = 1'b0; v1 = 1'b0; fend = 1'b0; sdend = 1'b0; sdinv = 1'b0; two = 1'b0;
        err_now = 1'b0; err_code = ST_RUN;
        nil = (r_len == LENGTH_COUNTER_WIDTH'(1)) && (r_first == CH_DASH);
        prod = {4'd0, r_acc} * 12'd10 + {4'd0, b - CH_ZERO};

        unique case (r_phase)
            PH_LT: begin
                if (b == CH_LT) begin
                    tag0 = TAG_PRI; n_phase = PH_PRI; clr = 1'b1;
                end else begin
                    err_now = 1'b1; err_code = ST_NOLT;
                end
            end
            PH_PRI: begin
                tag0 = TAG_PRI;
                if (b >= CH_ZERO && b <= CH_NINE) begin
                    n_acc = (prod > 12'd255) ? 8'd255 : prod[7:0];
                    bump = 1'b1; v0 = 1'b1;
                end else if (b == CH_GT) begin
                    fend = 1'b1;
                    if (r_len == '0) begin
                        err_now = 1'b1; err_code = ST_EMPTY;
                    end else if (r_acc > i_pri_limit) begin
                        err_now = 1'b1; err_code = ST_BADPRI;
                    end else begin
                        n_phase = PH_VER; clr = 1'b1;
                    end
                end else begin
                    err_now = 1'b1; err_code = ST_BADPRI;
                end
            end
            PH_VER, PH_TS, PH_HOST, PH_APP, PH_PROC, PH_MSGID: begin
                tag0 = r_phase;
                if (b == CH_SPACE) begin
                    fend = 1'b1;
                    if (r_len == '0) begin
                        err_now = 1'b1; err_code = ST_EMPTY;
                    end else if (r_phase == PH_VER &&
                                 r_len > LENGTH_COUNTER_WIDTH'(i_ver_max)) begin
                        err_now = 1'b1; err_code = ST_BADVER;
                    end else begin
                        n_phase = r_phase + 4'd1; clr = 1'b1;
                    end
                end else begin
                    bump = 1'b1; v0 = 1'b1;
                end
            end
            PH_SDSTART: begin
                if (b == CH_DASH) begin
                    n_phase = PH_SDNIL; clr = 1'b1; bump = 1'b1; tag0 = TAG_SDID;
                end else if (b == CH_LBR) begin
                    n_phase = PH_SDEL; n_sub = SUB_ID; n_esc = 1'b0; clr = 1'b1;
                    tag0 = TAG_SDID;
                end else begin
                    n_phase = PH_BODY; tag0 = TAG_BODY; v0 = 1'b1;
                end
            end
            PH_SDNIL: begin
                tag0 = TAG_SDID;
                if (b == CH_SPACE) begin
                    fend = 1'b1; n_phase = PH_BODY;
                end else begin
                    bump = 1'b1;
                end
            end
            PH_SDEL: begin
                unique case (r_sub)
                    SUB_ID, SUB_VALUE: begin
                        tag0 = (r_sub == SUB_ID) ? TAG_SDID : TAG_PVAL;
                        tag1 = tag0;
                        if (r_esc) begin
                            n_esc = 1'b0; v0 = 1'b1; bump = 1'b1;
                            if (!(b == CH_QUOTE || b == CH_RBR || b == CH_BSL)) begin
                                two = 1'b1; byte0 = CH_BSL; v1 = 1'b1; bump_bsl = 1'b1;
                            end
                        end else if (b == CH_BSL) begin
                            n_esc = 1'b1;
                        end else if (b == CH_RBR) begin
                            n_phase = PH_SDAFTER; n_sub = SUB_ID; n_esc = 1'b0;
                            if (r_sub == SUB_VALUE || r_len != '0) sdend = 1'b1;
                            if (r_sub == SUB_ID && r_len != '0) fend = 1'b1;
                        end else if (r_sub == SUB_ID && b == CH_SPACE) begin
                            if (r_len == '0) begin
                                n_sub = SUB_SKIP;
                            end else begin
                                fend = 1'b1; n_sub = SUB_NAME; clr = 1'b1;
                            end
                        end else if (r_sub == SUB_VALUE && b == CH_QUOTE) begin
                            fend = 1'b1; n_sub = SUB_AFTER;
                        end else begin
                            bump = 1'b1; v0 = 1'b1;
                        end
                    end
                    SUB_NAME: begin
                        tag0 = TAG_PNAME;
                        if (b == CH_EQ) begin
                            n_esc = 1'b0;
                            if (r_len == '0) begin
                                n_sub = SUB_SKIP;
                            end else begin
                                fend = 1'b1; n_sub = SUB_QUOTE; clr = 1'b1;
                            end
                        end else if (r_esc) begin
                            n_esc = 1'b0; bump = 1'b1; v0 = 1'b1;
                        end else if (b == CH_RBR) begin
                            sdend = 1'b1; n_phase = PH_SDAFTER; n_sub = SUB_ID;
                        end else begin
                            n_esc = (b == CH_BSL); bump = 1'b1; v0 = 1'b1;
                        end
                    end
                    SUB_QUOTE: begin
                        tag0 = TAG_PVAL;
                        if (b == CH_QUOTE) begin
                            n_sub = SUB_VALUE; clr = 1'b1;
                        end else if (b == CH_RBR) begin
                            sdend = 1'b1; n_phase = PH_SDAFTER; n_sub = SUB_ID; n_esc = 1'b0;
                        end else begin
                            n_esc = (b == CH_BSL); n_sub = SUB_SKIP;
                        end
                    end
                    SUB_AFTER: begin
                        tag0 = TAG_SDID;
                        if (b == CH_SPACE) begin
                            n_sub = SUB_NAME; clr = 1'b1;
                        end else if (b == CH_RBR) begin
                            sdend = 1'b1; n_phase = PH_SDAFTER; n_sub = SUB_ID; n_esc = 1'b0;
                        end else begin
                            n_esc = (b == CH_BSL); n_sub = SUB_SKIP;
                        end
                    end
                    default: begin
                        tag0 = TAG_SDID;
                        if (r_esc) begin
                            n_esc = 1'b0;
                        end else if (b == CH_BSL) begin
                            n_esc = 1'b1;
                        end else if (b == CH_RBR) begin
                            sdend = 1'b1; n_phase = PH_SDAFTER; n_sub = SUB_ID; n_esc = 1'b0;
                        end
                    end
                endcase
            end
            PH_SDAFTER: begin
                if (b == CH_LBR) begin
                    n_phase = PH_SDEL; n_sub = SUB_ID; n_esc = 1'b0; clr = 1'b1;
                    tag0 = TAG_SDID;
                end else if (b == CH_SPACE) begin
                    tag0 = TAG_SDID; n_phase = PH_BODY;
                end else begin
                    tag0 = TAG_BODY; v0 = 1'b1; sdinv = 1'b1; n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                tag0 = TAG_BODY; v0 = 1'b1;
            end
            default: begin
                tag0 = TAG_NONE;
            end
        endcase

        if (err_now) begin
            n_phase = PH_HALT;
            if (r_err == ST_RUN) n_err = err_code;
        end

        // Length and first-byte tracking (kept backslash counts first).
        len_a = clr ? '0 : r_len;
        first_a = clr ? 8'd0 : r_first;
        if (bump_bsl) begin
            if (len_a == '0) first_a = CH_BSL;
            if (len_a != LEN_MAX) len_a = len_a + 1'b1;
        end
        if (bump) begin
            if (len_a == '0) first_a = b;
            if (len_a != LEN_MAX) len_a = len_a + 1'b1;
        end
        n_len = len_a;
        n_first = first_a;

        // End-of-message adjustments; the body never counts as nil.
        if (eom) begin
            if (n_err == ST_RUN && n_phase < PH_SDSTART) begin
                n_err = ST_TRUNC; n_phase = PH_HALT;
            end
            if (n_phase == PH_BODY && tag0 == TAG_BODY) begin
                fend = 1'b1;
                nil = 1'b0;
            end
            if (n_phase == PH_SDNIL) begin
                fend = 1'b1;
                nil = (n_len == LENGTH_COUNTER_WIDTH'(1)) && (n_first == CH_DASH);
            end
        end
        if (!fend) nil = 1'b0;
        status = (n_err != ST_RUN) ? n_err : (eom ? ST_DONE : ST_RUN);

        // The flagged item is always the final one.
        o_entry.two = two;
        o_entry.first = '{field_tag: (two ? tag1 : tag0), out_byte: byte0,
                          byte_valid: (two ? v1 : v0),
                          field_end: (two ? 1'b0 : fend),
                          field_is_nil: (two ? 1'b0 : nil),
                          sd_element_end: (two ? 1'b0 : sdend),
                          sd_invalid: (two ? 1'b0 : sdinv),
                          prio_val: n_acc, facility: n_acc[7:3], severity: n_acc[2:0],
                          status: status, last: !two};
        o_entry.second = '{field_tag: tag0, out_byte: b, byte_valid: v0,
                           field_end: fend, field_is_nil: nil,
                           sd_element_end: sdend, sd_invalid: sdinv,
                           prio_val: n_acc, facility: n_acc[7:3], severity: n_acc[2:0],
                           status: status, last: 1'b1};
    end

endmodule
`default_nettype wire

[sv/smt_queue.sv]
// Short queue between the front classifier and the back emitter.
// Depends on smt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smt_queue import smt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    input  wire logic   i_pop,
    output logic        o_full,
    output logic        o_empty,
    output t_entry      o_entry
);

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr, r_rd;
    logic [QUEUE_AW:0]   r_cnt;

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr] <= i_entry;
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0; r_rd <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= r_wr + 1'b1;
            if (i_pop) r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QUEUE_AW+1)'(i_push) - (QUEUE_AW+1)'(i_pop);
        end
    end

    assign o_full  = (r_cnt == (QUEUE_AW+1)'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

endmodule
`default_nettype wire

[sv/smt_back.sv]
// Back part of the tokenizer: emits the one or two results of each queued byte.
// Depends on smt_pkg.
`timescale 1ns / 1ps
`default_nettype none
module smt_back import smt_pkg::*; (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_empty,
    input  wire t_entry i_entry,
    output logic        o_pop,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_out_item   o_item
);

    logic r_half;

    // Tracks whether the first of two results has been transferred.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half <= 1'b0;
        end else if (o_valid && i_ready) begin
            r_half <= i_entry.two && !r_half;
        end
    end

    assign o_valid = !i_empty;
    assign o_item  = (i_entry.two && !r_half) ? i_entry.first : i_entry.second;
    assign o_pop   = o_valid && i_ready && !(i_entry.two && !r_half);

endmodule
`default_nettype wire
